@@ rtl/sfq_pkg.sv @@
// Shared types and constants of the start-time fair queueing scheduler.
`default_nettype none
package sfq_pkg;

    // Default geometry.
    localparam int NUM_QUEUES_DEF     = 4;
    localparam int TAGS_PER_QUEUE_DEF = 16;

    // Field widths.
    localparam int TAG_W    = 48;
    localparam int BYTES_W  = 16;
    localparam int OVH_W    = 8;
    localparam int QIU_W    = 3;
    localparam int WGT_W    = 16;
    localparam int QIDX_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int WIRE_W   = BYTES_W + 1;
    localparam int INCR_W   = WIRE_W + WGT_W;

    // Stream payload widths (padded to whole bytes).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // Operation codes.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_SEL = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0  = 3'd2;
    localparam int NUM_WEIGHT_REGS = 4;

    // Reset values of the registers.
    localparam logic [QIU_W-1:0] QIU_RST = 3'd4;
    localparam logic [WGT_W-1:0] WGT_RST = 16'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch a new request
        logic mul;       // enqueue: form increment and start tag
        logic write;     // enqueue: store tags, update the flow
        logic scan;      // select: examine one queue
        logic pop;       // select: take the winner, read its next head
        logic fill;      // select: refill the head cache, clear if empty
        logic clear;     // clear the schedule
        logic load_out;  // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sel;
        logic rej;
        logic scan_last;
        logic any;
        logic idle;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/sfq_ctrl.sv @@
// Controller state machine of the scheduler.
`default_nettype none
module sfq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire sfq_pkg::sts_t sts,
    output sfq_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Next state and command decode.
    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                // The request is captured; route by operation.
                if (sts.is_sel) begin
                    state_next = S_SCAN;
                end else if (sts.rej) begin
                    state_next = S_DONE;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR: begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                if (sts.any) begin
                    cmd.pop    = 1'b1;
                    state_next = S_FILL;
                end else begin
                    cmd.clear  = !sts.idle;
                    state_next = S_DONE;
                end
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sfq_datapath.sv @@
// Datapath of the scheduler: registers, flow state, tag memory and result register.
`default_nettype none
module sfq_datapath #(
    parameter int NUM_QUEUES     = sfq_pkg::NUM_QUEUES_DEF,
    parameter int TAGS_PER_QUEUE = sfq_pkg::TAGS_PER_QUEUE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [sfq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sfq_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    input  wire logic                            in_op,
    input  wire logic [sfq_pkg::QIDX_W-1:0]      in_queue,
    input  wire logic [sfq_pkg::BYTES_W-1:0]     in_bytes,
    input  wire sfq_pkg::cmd_t                   cmd,
    output sfq_pkg::sts_t                        sts,
    output logic                                 out_found,
    output logic [sfq_pkg::QIDX_W-1:0]           out_queue,
    output logic                                 out_rejected,
    output logic [sfq_pkg::TAG_W-1:0]            out_vtime
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NW = $clog2(NUM_QUEUES + 1);
    localparam int CW = $clog2(TAGS_PER_QUEUE);
    localparam int KW = $clog2(TAGS_PER_QUEUE + 1);
    localparam int DEPTH = NUM_QUEUES * TAGS_PER_QUEUE;
    localparam int AW = $clog2(DEPTH);
    localparam int TW = sfq_pkg::TAG_W;
    localparam logic [TW-1:0] TAG_MAX = '1;

    // Configuration registers.
    logic [sfq_pkg::OVH_W-1:0] ovh_reg;
    logic [sfq_pkg::QIU_W-1:0] qiu_reg;
    logic [sfq_pkg::WGT_W-1:0] wgt_reg [NUM_QUEUES];

    // Flow state.
    logic [CW-1:0] head_reg  [NUM_QUEUES];
    logic [KW-1:0] count_reg [NUM_QUEUES];
    logic [TW-1:0] lfin_reg  [NUM_QUEUES];
    logic [TW-1:0] htag_reg  [NUM_QUEUES];
    logic [TW-1:0] vt_reg;
    logic          idle_reg;

    // Tag memory: start tags, one region per queue.
    logic [TW-1:0] mem [DEPTH];
    logic [TW-1:0] rdata_reg;

    // Captured request and working registers.
    logic                         op_reg;
    logic [QW-1:0]                q_reg;
    logic [sfq_pkg::BYTES_W-1:0]  bytes_reg;
    logic                         rej_reg;
    logic [sfq_pkg::INCR_W-1:0]   incr_reg;
    logic [TW-1:0]                start_reg;
    logic [QW-1:0]                idx_reg;
    logic                         any_reg;
    logic [QW-1:0]                best_reg;
    logic [TW-1:0]                best_tag_reg;

    // Result register.
    logic                         found_reg;
    logic [sfq_pkg::QIDX_W-1:0]   sel_reg;
    logic                         orej_reg;
    logic [TW-1:0]                ovt_reg;

    logic [NW-1:0]                n_act;
    logic [QW-1:0]                in_qi;
    logic                         in_rej;
    logic                         left;
    logic [CW:0]                  slot_sum;
    logic [CW-1:0]                slot;
    logic [CW-1:0]                new_head;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [sfq_pkg::WIRE_W-1:0]   wire_len;
    logic [TW:0]                  fin_sum;
    logic [TW-1:0]                fin;
    logic [sfq_pkg::CFG_IDX_W-1:0] widx;

    // Number of queues in use, clamped to one and to NUM_QUEUES.
    always_comb begin
        if (qiu_reg == '0) begin
            n_act = NW'(1);
        end else if (32'(qiu_reg) > NUM_QUEUES) begin
            n_act = NW'(NUM_QUEUES);
        end else begin
            n_act = NW'(qiu_reg);
        end
    end

    // Reject check on the incoming request.
    assign in_qi  = QW'(in_queue);
    assign in_rej = (32'(in_queue) >= 32'(n_act)) ||
                    (32'(count_reg[in_qi]) >= TAGS_PER_QUEUE);

    // Some queue in use still holds an entry.
    always_comb begin
        left = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if ((q < 32'(n_act)) && (count_reg[q] != '0)) begin
                left = 1'b1;
            end
        end
    end

    // Write slot and address of an enqueue.
    assign slot_sum = (CW+1)'(head_reg[q_reg]) + (CW+1)'(count_reg[q_reg]);
    assign slot     = (32'(slot_sum) >= TAGS_PER_QUEUE) ?
                      CW'(32'(slot_sum) - TAGS_PER_QUEUE) : CW'(slot_sum);
    assign wr_addr  = AW'(AW'(q_reg) * AW'(TAGS_PER_QUEUE)) + AW'(slot);

    // Next head and its address after a pop.
    assign new_head = (32'(head_reg[best_reg]) + 1 >= TAGS_PER_QUEUE) ?
                      '0 : CW'(head_reg[best_reg] + CW'(1));
    assign rd_addr  = AW'(AW'(best_reg) * AW'(TAGS_PER_QUEUE)) + AW'(new_head);

    // Finish tag with saturation.
    assign wire_len = sfq_pkg::WIRE_W'(bytes_reg) + sfq_pkg::WIRE_W'(ovh_reg);
    assign fin_sum  = (TW+1)'(start_reg) + (TW+1)'(incr_reg);
    assign fin      = fin_sum[TW] ? TAG_MAX : fin_sum[TW-1:0];

    assign widx = cfg_index - sfq_pkg::REG_WEIGHT0;

    // Status to the controller.
    assign sts.is_sel    = (op_reg == sfq_pkg::OP_SEL);
    assign sts.rej       = rej_reg;
    assign sts.scan_last = (32'(idx_reg) + 1 >= 32'(n_act));
    assign sts.any       = any_reg;
    assign sts.idle      = idle_reg;

    assign out_found    = found_reg;
    assign out_queue    = sel_reg;
    assign out_rejected = orej_reg;
    assign out_vtime    = ovt_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovh_reg <= '0;
            qiu_reg <= sfq_pkg::QIU_RST;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                wgt_reg[q] <= sfq_pkg::WGT_RST;
            end
        end else if (cfg_we) begin
            if (cfg_index == sfq_pkg::REG_OVERHEAD) begin
                ovh_reg <= cfg_wdata[sfq_pkg::OVH_W-1:0];
            end else if (cfg_index == sfq_pkg::REG_QUEUES) begin
                qiu_reg <= cfg_wdata[sfq_pkg::QIU_W-1:0];
            end else if ((cfg_index >= sfq_pkg::REG_WEIGHT0) &&
                         (32'(widx) < sfq_pkg::NUM_WEIGHT_REGS) &&
                         (32'(widx) < NUM_QUEUES)) begin
                wgt_reg[QW'(widx)] <= cfg_wdata[sfq_pkg::WGT_W-1:0];
            end
        end
    end

    // Flow state, virtual time and idle flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                head_reg[q]  <= '0;
                count_reg[q] <= '0;
                lfin_reg[q]  <= '0;
            end
            vt_reg   <= '0;
            idle_reg <= 1'b1;
        end else begin
            if (cmd.write) begin
                count_reg[q_reg] <= count_reg[q_reg] + KW'(1);
                lfin_reg[q_reg]  <= fin;
                idle_reg         <= 1'b0;
            end
            if (cmd.pop) begin
                vt_reg              <= best_tag_reg;
                head_reg[best_reg]  <= new_head;
                count_reg[best_reg] <= count_reg[best_reg] - KW'(1);
            end
            // Clearing happens on an empty select or once the last entry is served.
            if (cmd.clear || (cmd.fill && !left)) begin
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    head_reg[q]  <= '0;
                    count_reg[q] <= '0;
                    lfin_reg[q]  <= '0;
                end
                vt_reg   <= '0;
                idle_reg <= 1'b1;
            end
        end
    end

    // Tag memory with registered read.
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[wr_addr] <= start_reg;
        end
        if (cmd.pop) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Head tag cache, valid while the queue holds entries.
    always_ff @(posedge aclk) begin
        if (cmd.write && (count_reg[q_reg] == '0)) begin
            htag_reg[q_reg] <= start_reg;
        end
        if (cmd.fill && (count_reg[best_reg] != '0)) begin
            htag_reg[best_reg] <= rdata_reg;
        end
    end

    // Request capture, enqueue arithmetic and select scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                op_reg    <= in_op;
                q_reg     <= in_qi;
                bytes_reg <= in_bytes;
                rej_reg   <= (in_op == sfq_pkg::OP_ENQ) && in_rej;
                idx_reg   <= '0;
                any_reg   <= 1'b0;
                best_reg  <= '0;
            end
            if (cmd.mul) begin
                incr_reg  <= sfq_pkg::INCR_W'(wire_len) * sfq_pkg::INCR_W'(wgt_reg[q_reg]);
                start_reg <= (vt_reg > lfin_reg[q_reg]) ? vt_reg : lfin_reg[q_reg];
            end
            if (cmd.scan) begin
                idx_reg <= idx_reg + QW'(1);
                if ((count_reg[idx_reg] != '0) &&
                    (!any_reg || (htag_reg[idx_reg] < best_tag_reg))) begin
                    any_reg      <= 1'b1;
                    best_reg     <= idx_reg;
                    best_tag_reg <= htag_reg[idx_reg];
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            found_reg <= sts.is_sel && any_reg;
            sel_reg   <= (sts.is_sel && any_reg) ? sfq_pkg::QIDX_W'(best_reg) : '0;
            orej_reg  <= rej_reg;
            ovt_reg   <= vt_reg;
        end
    end

endmodule
`default_nettype wire

@@ rtl/start_time_fair_queue_scheduler_unit.sv @@
// Top level of the start-time fair queueing scheduler.
//
// Requests arrive on the s_ stream: tuser carries the operation (enqueue or
// select), tdata the queue index and packet size. Each request gives exactly
// one result on the m_ stream: found, selected queue, rejected and the
// virtual time after the request.
// An enqueue passes weight multiply, tag store and result load; a rejected
// enqueue skips multiply and store. A select scans the queues in use, one
// comparator walking the cached head tags one queue per cycle, then the tag
// memory port reads the winner's next head; pop and refill are skipped when
// nothing waits.
// One request is processed at a time; the next is taken once the previous
// result has entered the output register, even while it waits there.
// If the receiver stalls with a result pending, the next result waits in
// the datapath and no further request is taken.
// Reset (aresetn low, synchronous) empties all queues, zeroes virtual time
// and restores the register defaults; the tag memory needs no clearing.
// Configuration writes take effect at once; users make them while idle, unenforced.
`default_nettype none
module start_time_fair_queue_scheduler_unit #(
    parameter int NUM_QUEUES     = sfq_pkg::NUM_QUEUES_DEF,
    parameter int TAGS_PER_QUEUE = sfq_pkg::TAGS_PER_QUEUE_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [sfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sfq_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] queue_index, [17:2] packet_bytes, [23:18] zero
    input  wire logic [sfq_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] op
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] found, [2:1] selected_queue, [3] rejected, [51:4] virtual_now, [55:52] zero
    output logic [sfq_pkg::M_TDATA_W-1:0]         m_tdata
);

    sfq_pkg::cmd_t cmd;
    sfq_pkg::sts_t sts;

    logic                           out_found;
    logic [sfq_pkg::QIDX_W-1:0]     out_queue;
    logic                           out_rejected;
    logic [sfq_pkg::TAG_W-1:0]      out_vtime;

    sfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfq_datapath #(
        .NUM_QUEUES     (NUM_QUEUES),
        .TAGS_PER_QUEUE (TAGS_PER_QUEUE)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_op        (s_tuser),
        .in_queue     (s_tdata[1:0]),
        .in_bytes     (s_tdata[17:2]),
        .cmd          (cmd),
        .sts          (sts),
        .out_found    (out_found),
        .out_queue    (out_queue),
        .out_rejected (out_rejected),
        .out_vtime    (out_vtime)
    );

    assign m_tdata = {4'b0000, out_vtime, out_rejected, out_queue, out_found};

endmodule
`default_nettype wire

@@ dv/start_time_fair_queue_scheduler_unit_tb.sv @@
// Self-checking testbench of the start-time fair queueing scheduler.
`timescale 1ns / 100ps
`default_nettype none
module start_time_fair_queue_scheduler_unit_tb;
    import sfq_pkg::*;

    localparam int NQ = 4;
    localparam int DEPTH = 16;
    localparam logic [TAG_W-1:0] TAG_SAT = {TAG_W{1'b1}};
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQUESTS = 700;

    // Idling phases.
    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_t;

    typedef struct packed {
        logic                  found;
        logic [QIDX_W-1:0]     sel_q;
        logic                  rej;
        logic [TAG_W-1:0]      vnow;
    } sched_result_t;

    typedef struct {
        logic                  op;
        logic [QIDX_W-1:0]     qidx;
        logic [BYTES_W-1:0]    nbytes;
        logic                  typed;
        sched_result_t         res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    start_time_fair_queue_scheduler_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    // Shadow scheduler state.
    logic [OVH_W-1:0]  sh_overhead;
    logic [QIU_W-1:0]  sh_queues;
    logic [WGT_W-1:0]  sh_weight [NQ];
    logic [TAG_W-1:0]  sh_start [NQ][DEPTH];
    int                sh_head [NQ];
    int                sh_count [NQ];
    logic [TAG_W-1:0]  sh_last [NQ];
    logic [TAG_W-1:0]  sh_vtime;
    logic              sh_idle;

    sched_result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    idle_phase_t phase = PH_NONE;

    function automatic int queues_active();
        if (sh_queues < 1) return 1;
        if (sh_queues > NQ) return NQ;
        return int'(sh_queues);
    endfunction

    function automatic void clear_shadow();
        for (int q = 0; q < NQ; q++) begin
            sh_last[q] = '0;
            sh_head[q] = 0;
            sh_count[q] = 0;
        end
        sh_vtime = '0;
        sh_idle = 1'b1;
    endfunction

    function automatic void reset_shadow();
        sh_overhead = '0;
        sh_queues = QIU_RST;
        for (int q = 0; q < NQ; q++) sh_weight[q] = WGT_RST;
        clear_shadow();
    endfunction

    // Works out the result of one request and advances the shadow state.
    function automatic sched_result_t schedule_step(logic op, logic [QIDX_W-1:0] qi,
                                                    logic [BYTES_W-1:0] nb);
        sched_result_t r;
        int n;
        int best;
        bit any;
        bit left;
        logic [TAG_W-1:0] best_tag;
        logic [TAG_W:0] fin;
        logic [TAG_W:0] incr;
        logic [TAG_W-1:0] st;
        r = '0;
        n = queues_active();
        best = 0;
        any = 0;
        left = 0;
        best_tag = '0;
        if (op == OP_ENQ) begin
            if (int'(qi) >= n || sh_count[qi] >= DEPTH) begin
                r.rej = 1'b1;
            end else begin
                st = (sh_vtime > sh_last[qi]) ? sh_vtime : sh_last[qi];
                incr = (TAG_W+1)'(nb) + (TAG_W+1)'(sh_overhead);
                incr = incr * (TAG_W+1)'(sh_weight[qi]);
                fin = {1'b0, st} + incr;
                if (fin > {1'b0, TAG_SAT}) fin = {1'b0, TAG_SAT};
                sh_start[qi][(sh_head[qi] + sh_count[qi]) % DEPTH] = st;
                sh_count[qi]++;
                sh_last[qi] = fin[TAG_W-1:0];
                sh_idle = 1'b0;
            end
        end else begin
            for (int q = 0; q < n; q++) begin
                if (sh_count[q] != 0 && (!any || sh_start[q][sh_head[q]] < best_tag)) begin
                    any = 1;
                    best = q;
                    best_tag = sh_start[q][sh_head[q]];
                end
            end
            if (any) begin
                r.found = 1'b1;
                r.sel_q = QIDX_W'(best);
                sh_vtime = best_tag;
                sh_head[best] = (sh_head[best] + 1) % DEPTH;
                sh_count[best]--;
                for (int q = 0; q < n; q++) if (sh_count[q] != 0) left = 1;
                if (!left) clear_shadow();
            end else if (!sh_idle) begin
                clear_shadow();
            end
        end
        r.vnow = sh_vtime;
        return r;
    endfunction

    // Sends one request, holding it until it is taken. The valid stays high
    // afterwards until the next request or the drain replaces it.
    task automatic send_request(logic op, logic [QIDX_W-1:0] qi, logic [BYTES_W-1:0] nb,
                                logic typed, sched_result_t typed_res);
        sched_result_t r;
        while ((phase == PH_SEND || phase == PH_BOTH) && $urandom_range(99) < 56) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, nb, qi};
        r = schedule_step(op, qi, nb);
        if (typed && r != typed_res) begin
            $error("directed row: table expects %h, predictor gives %h", typed_res, r);
            errors++;
        end
        expected_results.push_back(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OVERHEAD: sh_overhead = val[OVH_W-1:0];
            REG_QUEUES:   sh_queues = val[QIU_W-1:0];
            default: if (idx >= REG_WEIGHT0 && idx < REG_WEIGHT0 + NUM_WEIGHT_REGS)
                sh_weight[idx - REG_WEIGHT0] = val;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // Receiver stall pattern.
    always @(negedge aclk) begin
        if (phase == PH_RECV || phase == PH_BOTH) m_tready <= ($urandom_range(99) >= 56);
        else m_tready <= 1'b1;
    end

    // Result checker.
    always @(posedge aclk) begin
        sched_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[2:1], m_tdata[3], m_tdata[TAG_W+3:4]};
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding: %h", got);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, got.found); errors++;
                end
                if (got.sel_q !== exp_r.sel_q) begin
                    $error("selected_queue: expected %0d, got %0d", exp_r.sel_q, got.sel_q);
                    errors++;
                end
                if (got.rej !== exp_r.rej) begin
                    $error("rejected: expected %0d, got %0d", exp_r.rej, got.rej); errors++;
                end
                if (got.vnow !== exp_r.vnow) begin
                    $error("virtual_now: expected %h, got %h", exp_r.vnow, got.vnow); errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("start_time_fair_queue_scheduler_unit_tb failed");
            $finish;
        end
    end

    // Directed table: typed results only where obvious.
    stim_row_t directed [] = '{
        '{OP_SEL, 2'd0, 16'd0,     1'b1, '{1'b0, 2'd0, 1'b0, 48'd0}},
        '{OP_ENQ, 2'd0, 16'd0,     1'b1, '{1'b0, 2'd0, 1'b0, 48'd0}},
        '{OP_ENQ, 2'd1, 16'hFFFF,  1'b0, '0},
        '{OP_ENQ, 2'd2, 16'd100,   1'b0, '0},
        '{OP_ENQ, 2'd3, 16'd1,     1'b0, '0},
        '{OP_ENQ, 2'd0, 16'd1500,  1'b0, '0},
        '{OP_SEL, 2'd3, 16'hFFFF,  1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0},
        '{OP_SEL, 2'd0, 16'd0,     1'b0, '0}
    };

    // Random request: enqueue/select traffic, mostly sizes up to 1600 bytes.
    task automatic random_request();
        logic op;
        logic [BYTES_W-1:0] nb;
        op = ($urandom_range(99) < 52) ? OP_ENQ : OP_SEL;
        nb = ($urandom_range(9) == 0) ? BYTES_W'($urandom) : BYTES_W'($urandom_range(1600));
        send_request(op, QIDX_W'($urandom_range(3)), nb, 1'b0, '0);
    endtask

    initial begin
        reset_shadow();
        for (int q = 0; q < NQ; q++)
            for (int k = 0; k < DEPTH; k++) sh_start[q][k] = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at reset settings.
        foreach (directed[i])
            send_request(directed[i].op, directed[i].qidx, directed[i].nbytes,
                         directed[i].typed, directed[i].res);
        wait_drained();

        // Fill queue 0 past full, with the unused-queue case and maximum weight and size.
        write_register(REG_QUEUES, 3'd1);
        write_register(REG_WEIGHT0, 16'hFFFF);
        write_register(REG_OVERHEAD, 8'hFF);
        for (int i = 0; i < DEPTH + 2; i++) send_request(OP_ENQ, 2'd0, 16'hFFFF, 1'b0, '0);
        send_request(OP_ENQ, 2'd2, 16'd5, 1'b1, '{1'b0, 2'd0, 1'b1, 48'd0});
        wait_drained();
        write_register(REG_QUEUES, 3'd0);
        repeat (DEPTH + 1) send_request(OP_SEL, 2'd0, 16'd0, 1'b0, '0);
        wait_drained();

        // Random phases over several register settings.
        for (int p = 0; p < 8; p++) begin
            phase = idle_phase_t'(p % 4);
            write_register(REG_OVERHEAD, (p == 1) ? 16'd0 : 16'($urandom_range(255)));
            write_register(REG_QUEUES, (p == 2) ? 16'd7 : 16'($urandom_range(7)));
            for (int q = 0; q < NQ; q++)
                write_register(CFG_IDX_W'(REG_WEIGHT0 + q),
                               (p == 3) ? 16'(q == 0 ? 0 : (q == 1 ? 1 : 16'hFFFF))
                                        : 16'($urandom_range(1, 1024)));
            for (int i = 0; i < RANDOM_REQUESTS / 8; i++) random_request();
            wait_drained();
        end
        phase = PH_NONE;
        write_register(3'd7, 16'hFFFF);
        wait_drained();

        if (errors == 0) begin
            $display("start_time_fair_queue_scheduler_unit_tb passed");
        end else begin
            $display("start_time_fair_queue_scheduler_unit_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ start_time_fair_queue_scheduler_unit.f @@
rtl/sfq_pkg.sv
rtl/sfq_ctrl.sv
rtl/sfq_datapath.sv
rtl/start_time_fair_queue_scheduler_unit.sv
dv/start_time_fair_queue_scheduler_unit_tb.sv
